FILE: rtl/ldr_pkg.sv
// shared types, register map and codes for the light dimmer ramp controller
`default_nettype none

package ldr_pkg;

    // level and config field widths
    localparam int LVL_W  = 16;
    localparam int MODE_W = 2;
    localparam int PORT_W = 2;

    // configuration port geometry
    localparam int REG_COUNT = 8;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_LIGHT_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_TWO_INPUTS    = 3'd1;
    localparam logic [IDX_W-1:0] REG_ON_IS_MAX     = 3'd2;
    localparam logic [IDX_W-1:0] REG_OFF_LEVEL     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_LEVEL     = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_LEVEL     = 3'd5;
    localparam logic [IDX_W-1:0] REG_STEP_SIZE     = 3'd6;
    localparam logic [IDX_W-1:0] REG_GROWTH_FACTOR = 3'd7;

    // register reset values
    localparam logic [LVL_W-1:0] RST_OFF_LEVEL     = 16'd0;
    localparam logic [LVL_W-1:0] RST_MIN_LEVEL     = 16'd3840;
    localparam logic [LVL_W-1:0] RST_MAX_LEVEL     = 16'd25600;
    localparam logic [LVL_W-1:0] RST_STEP_SIZE     = 16'd256;
    localparam logic [LVL_W-1:0] RST_GROWTH_FACTOR = 16'd0;

    // light modes
    localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEVEL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIMMER = 2'd2;

    // message ports
    localparam logic [PORT_W-1:0] PORT_SWITCH = 2'd0;
    localparam logic [PORT_W-1:0] PORT_UP     = 2'd1;
    localparam logic [PORT_W-1:0] PORT_DOWN   = 2'd2;
    localparam logic [PORT_W-1:0] PORT_REPORT = 2'd3;

    // item opcodes
    localparam logic OP_MSG  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // plain switch output levels
    localparam logic [LVL_W-1:0] LVL_ON_PLAIN  = 16'd1;
    localparam logic [LVL_W-1:0] LVL_OFF_PLAIN = 16'd0;

    // rounding offset for the Q16.16 product
    localparam logic [2*LVL_W:0] PROP_ROUND = 33'h0_0000_8000;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0] light_mode;
        logic              two_inputs;
        logic              on_is_max;
        logic [LVL_W-1:0]  off_level;
        logic [LVL_W-1:0]  min_level;
        logic [LVL_W-1:0]  max_level;
        logic [LVL_W-1:0]  step_size;
        logic [LVL_W-1:0]  growth_factor;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/ldr_if.sv
// valid/ready channel interfaces for input items and result items
`default_nettype none

interface ldr_in_if;
    import ldr_pkg::*;
    logic              valid;
    logic              ready;
    logic              op;
    logic [PORT_W-1:0] port;
    logic              payload_on;
    logic [LVL_W-1:0]  level_value;
    logic              readback_ok;

    modport source (output valid, op, port, payload_on, level_value, readback_ok,
                    input ready);
    modport sink   (input valid, op, port, payload_on, level_value, readback_ok,
                    output ready);
endinterface

interface ldr_out_if;
    import ldr_pkg::*;
    logic             valid;
    logic             ready;
    logic             write_valid;
    logic [LVL_W-1:0] write_level;
    logic             ramp_running;

    modport source (output valid, write_valid, write_level, ramp_running,
                    input ready);
    modport sink   (input valid, write_valid, write_level, ramp_running,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/light_dimmer_ramp_controller.sv
// top level of the light dimmer ramp controller
//
//  channel  | dir | transfer when          | payload
//  ---------+-----+------------------------+-------------------------------------------
//  i_in     | in  | valid && ready         | op, port, payload_on, level_value, readback_ok
//  o_out    | out | valid && ready         | write_valid, write_level, ramp_running
//  apb      | in  | psel && penable && pwrite | paddr, pwdata (prdata on reads)
//
//  one item per cycle sustained while o_out is ready; an input transfer is registered
//  in the input register, feeds the ramp step multiplier and clamp, then the result register
//  a stalled result holds the result register; the input register still takes one item
//  synchronous active-low reset clears control state and loads register defaults
`default_nettype none

module light_dimmer_ramp_controller
    import ldr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ldr_in_if.sink                 i_in,
    ldr_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    t_cfg w_cfg;

    ldr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ldr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/ldr_cfg_regs.sv
// apb-style configuration register bank
`default_nettype none

module ldr_cfg_regs
    import ldr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg             r_cfg;
    logic [IDX_W-1:0] w_idx;
    logic             w_wr;

    assign w_idx  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_mode    <= MODE_SWITCH;
            r_cfg.two_inputs    <= 1'b0;
            r_cfg.on_is_max     <= 1'b0;
            r_cfg.off_level     <= RST_OFF_LEVEL;
            r_cfg.min_level     <= RST_MIN_LEVEL;
            r_cfg.max_level     <= RST_MAX_LEVEL;
            r_cfg.step_size     <= RST_STEP_SIZE;
            r_cfg.growth_factor <= RST_GROWTH_FACTOR;
        end else if (w_wr) begin
            case (w_idx)
                REG_LIGHT_MODE:    r_cfg.light_mode    <= pwdata[MODE_W-1:0];
                REG_TWO_INPUTS:    r_cfg.two_inputs    <= pwdata[0];
                REG_ON_IS_MAX:     r_cfg.on_is_max     <= pwdata[0];
                REG_OFF_LEVEL:     r_cfg.off_level     <= pwdata[LVL_W-1:0];
                REG_MIN_LEVEL:     r_cfg.min_level     <= pwdata[LVL_W-1:0];
                REG_MAX_LEVEL:     r_cfg.max_level     <= pwdata[LVL_W-1:0];
                REG_STEP_SIZE:     r_cfg.step_size     <= pwdata[LVL_W-1:0];
                REG_GROWTH_FACTOR: r_cfg.growth_factor <= pwdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_LIGHT_MODE:    prdata = {{(DATA_W-MODE_W){1'b0}}, r_cfg.light_mode};
            REG_TWO_INPUTS:    prdata = {{(DATA_W-1){1'b0}}, r_cfg.two_inputs};
            REG_ON_IS_MAX:     prdata = {{(DATA_W-1){1'b0}}, r_cfg.on_is_max};
            REG_OFF_LEVEL:     prdata = {{(DATA_W-LVL_W){1'b0}}, r_cfg.off_level};
            REG_MIN_LEVEL:     prdata = {{(DATA_W-LVL_W){1'b0}}, r_cfg.min_level};
            REG_MAX_LEVEL:     prdata = {{(DATA_W-LVL_W){1'b0}}, r_cfg.max_level};
            REG_STEP_SIZE:     prdata = {{(DATA_W-LVL_W){1'b0}}, r_cfg.step_size};
            REG_GROWTH_FACTOR: prdata = {{(DATA_W-LVL_W){1'b0}}, r_cfg.growth_factor};
            default:           prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ldr_ramp_step.sv
// one ramp step: step plus rounded proportional term, then clamp
`default_nettype none

module ldr_ramp_step
    import ldr_pkg::*;
(
    input  wire logic [LVL_W-1:0] i_base,
    input  wire logic             i_upward,
    input  wire t_cfg             i_cfg,
    output logic      [LVL_W-1:0] o_level,
    output logic                  o_at_limit
);

    logic [2*LVL_W-1:0] w_prod;
    logic [2*LVL_W:0]   w_rnd;
    logic [LVL_W:0]     w_prop;
    logic [LVL_W-1:0]   w_step;
    logic [LVL_W+1:0]   w_delta;
    logic [LVL_W+2:0]   w_sum;
    logic               w_neg;
    logic [LVL_W-1:0]   w_diff;

    // proportional term, rounded half up
    assign w_prod  = {{LVL_W{1'b0}}, i_cfg.growth_factor} * {{LVL_W{1'b0}}, i_base};
    assign w_rnd   = {1'b0, w_prod} + PROP_ROUND;
    assign w_prop  = w_rnd[2*LVL_W:LVL_W];
    assign w_step  = (i_cfg.step_size == '0) ? LVL_ON_PLAIN : i_cfg.step_size;
    assign w_delta = {2'b00, w_step} + {1'b0, w_prop};

    // full-width sum and difference
    assign w_sum  = {3'b000, i_base} + {1'b0, w_delta};
    assign w_neg  = {2'b00, i_base} < w_delta;
    assign w_diff = i_base - w_delta[LVL_W-1:0];

    // clamp, max first (an underflow on the way down goes to min)
    always_comb begin
        if (i_upward) begin
            if (w_sum > {3'b000, i_cfg.max_level}) begin
                o_level = i_cfg.max_level;
            end else if (w_sum < {3'b000, i_cfg.min_level}) begin
                o_level = i_cfg.min_level;
            end else begin
                o_level = w_sum[LVL_W-1:0];
            end
        end else begin
            if (w_neg) begin
                o_level = i_cfg.min_level;
            end else if (w_diff > i_cfg.max_level) begin
                o_level = i_cfg.max_level;
            end else if (w_diff < i_cfg.min_level) begin
                o_level = i_cfg.min_level;
            end else begin
                o_level = w_diff;
            end
        end
    end

    assign o_at_limit = i_upward ? (o_level == i_cfg.max_level)
                                 : (o_level == i_cfg.min_level);

endmodule

`default_nettype wire

FILE: rtl/ldr_core.sv
// input register, controller state, decision logic and result register
`default_nettype none

module ldr_core
    import ldr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    ldr_in_if.sink    i_in,
    ldr_out_if.source o_out
);

    // input stage
    logic              r_in_valid;
    logic              r_in_op;
    logic [PORT_W-1:0] r_in_port;
    logic              r_in_pressed;
    logic [LVL_W-1:0]  r_in_level;
    logic              r_in_rb;

    // controller state
    logic [LVL_W-1:0] r_ramp_level, n_ramp_level;
    logic             r_busy, n_busy;
    logic             r_upward, n_upward;
    logic [LVL_W-1:0] r_cached, n_cached;
    logic [LVL_W-1:0] r_remembered, n_remembered;

    // result stage
    logic             r_out_valid;
    logic             r_out_wv, n_out_wv;
    logic [LVL_W-1:0] r_out_wl, n_out_wl;
    logic             r_out_run;

    logic             w_adv;
    logic [LVL_W-1:0] w_base;
    logic             w_dir;
    logic [LVL_W-1:0] w_step_lvl;
    logic             w_at_limit;
    logic             w_on;
    logic             w_step_used;

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op      <= i_in.op;
            r_in_port    <= i_in.port;
            r_in_pressed <= i_in.payload_on;
            r_in_level   <= i_in.level_value;
            r_in_rb      <= i_in.readback_ok;
        end
    end

    // step operand: running level on a tick, start level on a press
    always_comb begin
        if (r_in_op == OP_TICK) begin
            w_base = r_ramp_level;
            w_dir  = r_upward;
        end else begin
            w_base = r_in_rb ? r_in_level : (r_busy ? r_ramp_level : r_cached);
            w_dir  = (r_in_port == PORT_UP);
        end
    end

    ldr_ramp_step u_step (
        .i_base     (w_base),
        .i_upward   (w_dir),
        .i_cfg      (i_cfg),
        .o_level    (w_step_lvl),
        .o_at_limit (w_at_limit)
    );

    // per-item decision
    always_comb begin
        n_ramp_level = r_ramp_level;
        n_busy       = r_busy;
        n_upward     = r_upward;
        n_cached     = r_cached;
        n_remembered = r_remembered;
        n_out_wv     = 1'b0;
        n_out_wl     = '0;
        w_on         = 1'b0;
        w_step_used  = 1'b0;
        if (r_in_op == OP_TICK) begin
            if (r_busy) begin
                w_step_used  = 1'b1;
                n_out_wv     = 1'b1;
                n_out_wl     = w_step_lvl;
                n_ramp_level = w_step_lvl;
                if (w_at_limit) begin
                    n_busy   = 1'b0;
                    n_cached = w_step_lvl;
                    if (w_step_lvl >= i_cfg.min_level && !i_cfg.on_is_max) begin
                        n_remembered = w_step_lvl;
                    end
                end
            end
        end else if (i_cfg.light_mode == MODE_DIMMER &&
                     (r_in_port inside {PORT_UP, PORT_DOWN})) begin
            // end any running ramp first
            if (r_busy) begin
                n_busy   = 1'b0;
                n_cached = r_ramp_level;
                if (r_ramp_level >= i_cfg.min_level && !i_cfg.on_is_max) begin
                    n_remembered = r_ramp_level;
                end
            end
            // press starts a new ramp with its first step
            if (r_in_pressed) begin
                w_step_used  = 1'b1;
                n_upward     = w_dir;
                n_busy       = 1'b1;
                n_out_wv     = 1'b1;
                n_out_wl     = w_step_lvl;
                n_ramp_level = w_step_lvl;
                if (w_at_limit) begin
                    n_busy   = 1'b0;
                    n_cached = w_step_lvl;
                    if (w_step_lvl >= i_cfg.min_level && !i_cfg.on_is_max) begin
                        n_remembered = w_step_lvl;
                    end
                end
            end
        end else if (r_in_port == PORT_REPORT) begin
            n_cached = r_in_level;
            if (r_in_level != '0) begin
                n_remembered = r_in_level;
            end
        end else if (!(i_cfg.two_inputs && !r_in_pressed)) begin
            w_on     = i_cfg.two_inputs ? (r_in_port == PORT_SWITCH) : r_in_pressed;
            n_out_wv = 1'b1;
            if (i_cfg.light_mode inside {MODE_LEVEL, MODE_DIMMER}) begin
                if (w_on) begin
                    n_out_wl = (r_remembered != '0) ? r_remembered : i_cfg.max_level;
                end else begin
                    n_out_wl = i_cfg.off_level;
                end
            end else begin
                n_out_wl = w_on ? LVL_ON_PLAIN : LVL_OFF_PLAIN;
            end
        end
    end

    // state update on each processed item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_level <= '0;
            r_busy       <= 1'b0;
            r_upward     <= 1'b0;
            r_cached     <= '0;
            r_remembered <= '0;
        end else if (w_adv) begin
            r_ramp_level <= n_ramp_level;
            r_busy       <= n_busy;
            r_upward     <= n_upward;
            r_cached     <= n_cached;
            r_remembered <= n_remembered;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_wv  <= n_out_wv;
            r_out_wl  <= n_out_wl;
            r_out_run <= n_busy;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.write_valid  = r_out_wv;
    assign o_out.write_level  = r_out_wl;
    assign o_out.ramp_running = r_out_run;

    // a tick with no ramp running gives a result without a write
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_op == OP_TICK && !r_busy) |=> (r_out_valid && !r_out_wv))
        else $error("idle tick produced a level write");

    // a result without a write carries a zero level
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !n_out_wv) |=> (r_out_wl == '0))
        else $error("result without write has nonzero level");

    // a step with ordered clamps lands inside them
    a_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_step_used && i_cfg.min_level <= i_cfg.max_level) |=>
        (r_ramp_level >= $past(i_cfg.min_level) && r_ramp_level <= $past(i_cfg.max_level)))
        else $error("ramp level outside clamps");

    // a ramp reported running follows a step write
    a_run_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_busy && n_busy) |=> (r_out_wv && r_out_run))
        else $error("ramp started without a step write");

endmodule

`default_nettype wire

FILE: verif/light_dimmer_ramp_controller_tb.sv
// self-checking testbench for the light dimmer ramp controller: predicted writes vs results
`default_nettype none

module light_dimmer_ramp_controller_tb
    import ldr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // light mode with no meaning of its own, behaves as plain switch
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT    = 500_000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_ITEMS    = 90;
    localparam int IDLE_MAX       = 17;
    localparam int LONG_HOLD      = 150;

    // one input transfer and one result transfer
    typedef struct packed {
        logic              op;
        logic [PORT_W-1:0] port;
        logic              payload_on;
        logic [LVL_W-1:0]  level_value;
        logic              readback_ok;
    } t_light_msg;

    typedef struct packed {
        logic             write_valid;
        logic [LVL_W-1:0] write_level;
        logic             ramp_running;
    } t_light_write;

    // predicts the level write each message causes and checks results in order
    class t_light_write_tracker;
        t_cfg             cfg;
        logic [LVL_W-1:0] lvl_now;
        logic [LVL_W-1:0] last_level;
        logic [LVL_W-1:0] on_memory;
        logic             ramping;
        logic             going_up;
        t_light_write     pending_writes[$];
        int               errors;

        function new();
            cfg.light_mode    = MODE_SWITCH;
            cfg.two_inputs    = 1'b0;
            cfg.on_is_max     = 1'b0;
            cfg.off_level     = RST_OFF_LEVEL;
            cfg.min_level     = RST_MIN_LEVEL;
            cfg.max_level     = RST_MAX_LEVEL;
            cfg.step_size     = RST_STEP_SIZE;
            cfg.growth_factor = RST_GROWTH_FACTOR;
            lvl_now    = '0;
            last_level = '0;
            on_memory  = '0;
            ramping    = 1'b0;
            going_up   = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(logic [IDX_W-1:0] idx, logic [LVL_W-1:0] value);
            case (idx)
                REG_LIGHT_MODE:    cfg.light_mode    = value[MODE_W-1:0];
                REG_TWO_INPUTS:    cfg.two_inputs    = value[0];
                REG_ON_IS_MAX:     cfg.on_is_max     = value[0];
                REG_OFF_LEVEL:     cfg.off_level     = value;
                REG_MIN_LEVEL:     cfg.min_level     = value;
                REG_MAX_LEVEL:     cfg.max_level     = value;
                REG_STEP_SIZE:     cfg.step_size     = value;
                REG_GROWTH_FACTOR: cfg.growth_factor = value;
                default: ;
            endcase
        endfunction

        // ramp over: cache the level, remember it as on level when allowed
        function void finish_ramp();
            last_level = lvl_now;
            if (lvl_now >= cfg.min_level && !cfg.on_is_max)
                on_memory = lvl_now;
            ramping = 1'b0;
        endfunction

        // one ramp step with rounded proportional part, clamped max first
        function logic [LVL_W-1:0] ramp_tick();
            longint inc;
            longint nxt;
            longint grow;
            longint cur;
            longint lo;
            longint hi;
            grow = cfg.growth_factor;
            cur  = lvl_now;
            lo   = cfg.min_level;
            hi   = cfg.max_level;
            inc  = (cfg.step_size == '0) ? 1 : cfg.step_size;
            inc  = inc + ((grow * cur + 32768) >>> 16);
            nxt  = going_up ? cur + inc : cur - inc;
            if (nxt > hi)
                nxt = hi;
            else if (nxt < lo)
                nxt = lo;
            lvl_now = LVL_W'(nxt);
            if ((going_up && lvl_now == cfg.max_level) ||
                (!going_up && lvl_now == cfg.min_level))
                finish_ramp();
            return lvl_now;
        endfunction

        function void take_item(t_light_msg m);
            t_light_write w;
            logic         turn_on;
            w = '0;
            if (m.op == OP_TICK) begin
                if (ramping) begin
                    w.write_level = ramp_tick();
                    w.write_valid = 1'b1;
                end
            end else if (cfg.light_mode == MODE_DIMMER &&
                         (m.port == PORT_UP || m.port == PORT_DOWN)) begin
                if (ramping)
                    finish_ramp();
                if (m.payload_on) begin
                    going_up      = (m.port == PORT_UP);
                    lvl_now       = m.readback_ok ? m.level_value : last_level;
                    ramping       = 1'b1;
                    w.write_level = ramp_tick();
                    w.write_valid = 1'b1;
                end
            end else if (m.port == PORT_REPORT) begin
                last_level = m.level_value;
                if (m.level_value != '0)
                    on_memory = m.level_value;
            end else if (!(cfg.two_inputs && !m.payload_on)) begin
                turn_on       = cfg.two_inputs ? (m.port == PORT_SWITCH) : m.payload_on;
                w.write_valid = 1'b1;
                if (cfg.light_mode == MODE_LEVEL || cfg.light_mode == MODE_DIMMER)
                    w.write_level = turn_on ? ((on_memory != '0) ? on_memory : cfg.max_level)
                                            : cfg.off_level;
                else
                    w.write_level = turn_on ? LVL_ON_PLAIN : LVL_OFF_PLAIN;
            end
            w.ramp_running = ramping;
            pending_writes.insert(pending_writes.size(), w);
        endfunction

        function void check_write(t_light_write got);
            t_light_write want;
            if (pending_writes.size() == 0) begin
                $display("%0t: result with nothing expected: valid %0d level %0d running %0d",
                         $time, got.write_valid, got.write_level, got.ramp_running);
                errors++;
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_valid !== want.write_valid) begin
                $display("%0t: write_valid expected %0d actual %0d",
                         $time, want.write_valid, got.write_valid);
                errors++;
            end
            if (got.write_level !== want.write_level) begin
                $display("%0t: write_level expected %0d actual %0d",
                         $time, want.write_level, got.write_level);
                errors++;
            end
            if (got.ramp_running !== want.ramp_running) begin
                $display("%0t: ramp_running expected %0d actual %0d",
                         $time, want.ramp_running, got.ramp_running);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    ldr_in_if  in_bus();
    ldr_out_if out_bus();

    t_light_write_tracker tracker;

    int n_sent       = 0;
    int n_recv       = 0;
    int in_gap_max   = IDLE_MAX;
    int out_stall_max = IDLE_MAX;
    int hold_request = 0;
    int cycle_count  = 0;

    light_dimmer_ramp_controller DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("light_dimmer_ramp_controller: mismatch");
            $finish;
        end
    end

    // note input transfers, then check result transfers, on the same edge
    always @(posedge i_clk) begin : transfer_monitor
        t_light_msg   seen_msg;
        t_light_write seen_write;
        if (i_rst_n) begin
            if (in_bus.valid && in_bus.ready) begin
                seen_msg.op          = in_bus.op;
                seen_msg.port        = in_bus.port;
                seen_msg.payload_on  = in_bus.payload_on;
                seen_msg.level_value = in_bus.level_value;
                seen_msg.readback_ok = in_bus.readback_ok;
                tracker.take_item(seen_msg);
            end
            if (out_bus.valid && out_bus.ready) begin
                seen_write.write_valid  = out_bus.write_valid;
                seen_write.write_level  = out_bus.write_level;
                seen_write.ramp_running = out_bus.ramp_running;
                tracker.check_write(seen_write);
                n_recv++;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                stall = hold_request;
                hold_request = 0;
            end else begin
                stall = $urandom_range(0, out_stall_max);
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid) @(posedge i_clk);
        end
    end

    function automatic t_light_msg make_msg(logic op, logic [PORT_W-1:0] port, logic on,
                                            logic [LVL_W-1:0] lvl, logic rb);
        t_light_msg m;
        m.op          = op;
        m.port        = port;
        m.payload_on  = on;
        m.level_value = lvl;
        m.readback_ok = rb;
        return m;
    endfunction

    function automatic logic [LVL_W-1:0] random_level();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return LVL_W'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic t_light_msg random_msg();
        t_light_msg m;
        m.op          = ($urandom_range(0, 3) == 0) ? OP_TICK : OP_MSG;
        m.port        = PORT_W'($urandom_range(0, 3));
        m.payload_on  = 1'($urandom_range(0, 1));
        m.level_value = random_level();
        m.readback_ok = 1'($urandom_range(0, 1));
        return m;
    endfunction

    // one input transfer after a random gap; valid stays up for back-to-back items
    task automatic send_item(input t_light_msg m);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.op          <= m.op;
        in_bus.port        <= m.port;
        in_bus.payload_on  <= m.payload_on;
        in_bus.level_value <= m.level_value;
        in_bus.readback_ok <= m.readback_ok;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        n_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (n_recv < n_sent) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LVL_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, value);
    endtask

    // random settings, extremes and inverted clamps included
    task automatic randomize_config(output bit dimming);
        int               pick;
        logic [LVL_W-1:0] lo;
        logic [LVL_W-1:0] hi;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(0, 9);
        mode = (pick < 6) ? MODE_DIMMER : (pick == 6) ? MODE_SWITCH :
               (pick == 7) ? MODE_LEVEL : MODE_SPARE;
        dimming = (mode == MODE_DIMMER);
        write_reg(REG_LIGHT_MODE, LVL_W'(mode));
        write_reg(REG_TWO_INPUTS, LVL_W'($urandom_range(0, 1)));
        write_reg(REG_ON_IS_MAX, LVL_W'($urandom_range(0, 1)));
        write_reg(REG_OFF_LEVEL, random_level());
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            lo = LVL_W'($urandom_range(0, 16'h4000));
            hi = LVL_W'($urandom_range(lo + 16'h1000, 16'hFFFF));
        end else if (pick == 7) begin
            lo = '0;
            hi = '1;
        end else if (pick == 8) begin
            lo = LVL_W'($urandom_range(16'h8000, 16'hFFFF));
            hi = LVL_W'($urandom_range(0, 16'h7FFF));
        end else begin
            lo = random_level();
            hi = lo;
        end
        write_reg(REG_MIN_LEVEL, lo);
        write_reg(REG_MAX_LEVEL, hi);
        pick = $urandom_range(0, 9);
        write_reg(REG_STEP_SIZE, (pick < 7) ? LVL_W'($urandom_range(1, 16'h0800)) :
                                 (pick == 7) ? '0 : (pick == 8) ? '1 :
                                 LVL_W'($urandom_range(0, 16'hFFFF)));
        pick = $urandom_range(0, 9);
        write_reg(REG_GROWTH_FACTOR, (pick < 6) ? LVL_W'($urandom_range(0, 16'h2000)) :
                                     (pick == 6) ? '0 : (pick == 7) ? '1 :
                                     LVL_W'($urandom_range(0, 16'hFFFF)));
    endtask

    // press, a run of ticks with the odd message mixed in, usually a release
    task automatic dim_sequence();
        t_light_msg m;
        int         ticks;
        m = random_msg();
        m.op         = OP_MSG;
        m.port       = $urandom_range(0, 1) ? PORT_UP : PORT_DOWN;
        m.payload_on = 1'b1;
        send_item(m);
        ticks = $urandom_range(1, 24);
        repeat (ticks) begin
            m = random_msg();
            if ($urandom_range(0, 7) != 0)
                m.op = OP_TICK;
            send_item(m);
        end
        if ($urandom_range(0, 5) != 0) begin
            m = random_msg();
            m.op         = OP_MSG;
            m.port       = $urandom_range(0, 1) ? PORT_UP : PORT_DOWN;
            m.payload_on = 1'b0;
            send_item(m);
        end
    endtask

    initial begin : stimulus
        int target;
        bit dimming;
        tracker = new();
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_bus.valid       <= 1'b0;
        in_bus.op          <= OP_MSG;
        in_bus.port        <= PORT_SWITCH;
        in_bus.payload_on  <= 1'b0;
        in_bus.level_value <= '0;
        in_bus.readback_ok <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // plain switch at reset settings, tick while idle
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b1, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b0, 16'hFFFF, 1'b1));
        send_item(make_msg(OP_TICK, PORT_REPORT, 1'b1, 16'hFFFF, 1'b1));
        send_item(make_msg(OP_MSG, PORT_DOWN, 1'b1, 16'h0000, 1'b0));

        // on/off level: on level is max while nothing is remembered, zero report
        settle();
        write_reg(REG_LIGHT_MODE, LVL_W'(MODE_LEVEL));
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b1, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_REPORT, 1'b1, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_UP, 1'b0, 16'h0000, 1'b0));

        // dimmer with zero step, full growth and full clamp range
        settle();
        write_reg(REG_LIGHT_MODE, LVL_W'(MODE_DIMMER));
        write_reg(REG_OFF_LEVEL, 16'hFFFF);
        write_reg(REG_STEP_SIZE, 16'h0000);
        write_reg(REG_GROWTH_FACTOR, 16'hFFFF);
        write_reg(REG_MIN_LEVEL, 16'h0000);
        write_reg(REG_MAX_LEVEL, 16'hFFFF);
        write_reg(REG_ON_IS_MAX, 16'h0001);
        write_reg(REG_TWO_INPUTS, 16'h0000);
        send_item(make_msg(OP_MSG, PORT_UP, 1'b1, 16'h5555, 1'b0));
        send_item(make_msg(OP_TICK, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_TICK, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        // switch during a ramp writes and the ramp carries on
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b1, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_UP, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_DOWN, 1'b1, 16'hFFFF, 1'b1));
        send_item(make_msg(OP_TICK, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_UP, 1'b1, 16'hFFFF, 1'b1));
        send_item(make_msg(OP_MSG, PORT_REPORT, 1'b0, 16'hFFFF, 1'b0));

        // inverted clamps and two-input switching
        settle();
        write_reg(REG_MIN_LEVEL, 16'hFFFF);
        write_reg(REG_MAX_LEVEL, 16'h0000);
        write_reg(REG_STEP_SIZE, 16'h0100);
        write_reg(REG_GROWTH_FACTOR, 16'h0000);
        write_reg(REG_ON_IS_MAX, 16'h0000);
        write_reg(REG_TWO_INPUTS, 16'h0001);
        send_item(make_msg(OP_MSG, PORT_DOWN, 1'b1, 16'h8000, 1'b1));
        send_item(make_msg(OP_TICK, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b1, 16'h0000, 1'b0));

        // ramp left running across a mode change keeps stepping
        settle();
        write_reg(REG_MIN_LEVEL, 16'h0F00);
        write_reg(REG_MAX_LEVEL, 16'h6400);
        write_reg(REG_GROWTH_FACTOR, 16'h0100);
        send_item(make_msg(OP_MSG, PORT_UP, 1'b1, 16'h2000, 1'b1));
        settle();
        write_reg(REG_LIGHT_MODE, LVL_W'(MODE_SWITCH));
        send_item(make_msg(OP_TICK, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_UP, 1'b1, 16'h0000, 1'b0));
        settle();
        write_reg(REG_LIGHT_MODE, LVL_W'(MODE_SPARE));
        send_item(make_msg(OP_TICK, PORT_SWITCH, 1'b0, 16'h0000, 1'b0));
        send_item(make_msg(OP_MSG, PORT_SWITCH, 1'b1, 16'h0000, 1'b0));

        // random phases, each under fresh settings and its own idling pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            randomize_config(dimming);
            case (ph % 4)
                0: begin
                    in_gap_max    = 0;
                    out_stall_max = 0;
                end
                1: begin
                    in_gap_max    = IDLE_MAX;
                    out_stall_max = 0;
                end
                2: begin
                    in_gap_max    = 0;
                    out_stall_max = IDLE_MAX;
                end
                default: begin
                    in_gap_max    = IDLE_MAX;
                    out_stall_max = IDLE_MAX;
                end
            endcase
            // back-to-back items against a long result hold-off
            if (ph == 2)
                hold_request = LONG_HOLD;
            target = n_sent + PHASE_ITEMS;
            while (n_sent < target) begin
                if ($urandom_range(0, 3) != 0 && (dimming || $urandom_range(0, 3) == 0))
                    dim_sequence();
                else
                    send_item(random_msg());
            end
        end

        settle();
        if (tracker.errors == 0 && tracker.pending_writes.size() == 0)
            $display("light_dimmer_ramp_controller: match");
        else
            $display("light_dimmer_ramp_controller: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
